[rtl/mfep_pkg.sv]
// shared types and constants for the midi file event parser
`timescale 1ns / 1ps
package mfep_pkg;

  typedef enum logic [3:0] {
    PH_HDR, PH_TRK, PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE,
    PH_META_LEN, PH_SYSEX_LEN, PH_TEMPO, PH_SKIP, PH_DONE, PH_DIV, PH_OUT
  } phase_e;

  typedef enum logic [3:0] {
    K_NOTE = 4'd0, K_POLY = 4'd1, K_CTRL = 4'd2, K_PROG = 4'd3, K_CHAT = 4'd4,
    K_PITCH = 4'd5, K_TEMPO = 4'd6, K_DIV = 4'd7, K_BAD_HDR = 4'd8,
    K_BAD_TRK = 4'd9, K_BAD_STAT = 4'd10
  } kind_e;

  localparam logic [31:0] TAG_HEADER = 32'h4D546864;
  localparam logic [31:0] TAG_TRACK = 32'h4D54726B;
  localparam logic [25:0] TEMPO_NUM = 26'd60000000;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_END = 8'h2F;

  // controller to datapath: start the tempo divider
  typedef struct packed {
    logic start;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[rtl/mfep_div.sv]
// restoring divider for the tempo, one quotient bit per cycle
`timescale 1ns / 1ps
module mfep_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mfep_pkg::div_cmd_t    cmd_i,
  input  logic [23:0]           divisor_i,
  output mfep_pkg::div_sts_t    sts_o,
  output logic [7:0]            bpm_o
);
  import mfep_pkg::*;

  logic [4:0]  cnt_q, cnt_d;
  logic [25:0] rem_q, rem_d, quo_q, quo_d;
  logic [23:0] dvs_q, dvs_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [26:0] trial;

  // done stays up until the next start
  always_comb begin
    cnt_d = cnt_q; rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q;
    busy_d = busy_q; done_d = done_q;
    trial = 27'd0;
    if (cmd_i.start) begin
      busy_d = 1'b1; done_d = 1'b0; cnt_d = 5'd25; rem_d = 26'd0; quo_d = TEMPO_NUM;
      dvs_d = divisor_i;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[25]} - {3'd0, dvs_q};
      if (!trial[26]) begin
        rem_d = trial[25:0];
        quo_d = {quo_q[24:0], 1'b1};
      end else begin
        rem_d = {rem_q[24:0], quo_q[25]};
        quo_d = {quo_q[24:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= 5'd0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign bpm_o = quo_q[7:0];
endmodule

[rtl/mfep_ctrl.sv]
// byte parser controller with track state and result register
`timescale 1ns / 1ps
module mfep_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           file_byte_i,
  input  logic                 restart_i,
  output mfep_pkg::div_cmd_t   div_cmd_o,
  output logic [23:0]          divisor_o,
  input  mfep_pkg::div_sts_t   div_sts_i,
  input  logic [7:0]           bpm_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [3:0]           kind_o,
  output logic [3:0]           channel_o,
  output logic [31:0]          timestamp_o,
  output logic [7:0]           status_o,
  output logic [7:0]           data_first_o,
  output logic [7:0]           data_second_o,
  output logic [15:0]          value_o
);
  import mfep_pkg::*;

  phase_e      ph_q, ph_d, ret_q, ret_d;
  logic [3:0]  pos_q, pos_d;
  logic [15:0] tdec_q, tdec_d, tfin_q, tfin_d;
  logic [31:0] left_q, left_d, tick_q, tick_d, vl_q, vl_d, skip_q, skip_d;
  logic [7:0]  rs_q, rs_d, held_q, held_d, dh_q, dh_d;
  logic [23:0] tempo_q, tempo_d;
  logic        end_q, end_d, halt_q, halt_d;
  logic        ov_q, ov_d;
  logic [3:0]  k_q, k_d, ch_q, ch_d;
  logic [31:0] ts_q, ts_d;
  logic [7:0]  st_q, st_d, d1_q, d1_d, d2_q, d2_d;
  logic [15:0] val_q, val_d;
  logic        accept, emit, finish, startdiv;
  logic [31:0] vl_n;
  logic [7:0]  b, hi;
  logic [8:0]  neg;
  logic [16:0] prod;
  phase_e      fin_ph;
  logic [3:0]  fin_pos;
  logic [15:0] fin_tfin;
  logic [31:0] left_n;

  assign b = file_byte_i;
  // stall while a waiting result is held by the receiver, or while a tempo event waits on the divider
  assign in_stall_o = (ov_q && out_stall_i) || ph_q == PH_DIV;
  assign accept = in_valid_i && !in_stall_o;
  assign vl_n = {vl_q[24:0], b[6:0]};
  assign hi = {rs_q[7:4], 4'd0};
  assign neg = 9'd256 - {1'b0, dh_q};
  assign prod = neg * {9'd0, b};

  always_comb begin
    ph_d = ph_q; ret_d = ret_q; pos_d = pos_q; tdec_d = tdec_q; tfin_d = tfin_q;
    left_d = left_q; tick_d = tick_q; vl_d = vl_q; skip_d = skip_q; rs_d = rs_q;
    held_d = held_q; dh_d = dh_q; tempo_d = tempo_q; end_d = end_q; halt_d = halt_q;
    emit = 1'b0; finish = 1'b0; startdiv = 1'b0;
    k_d = k_q; ch_d = 4'd0; ts_d = 32'd0; st_d = 8'd0; d1_d = 8'd0; d2_d = 8'd0;
    val_d = 16'd0;
    left_n = left_q;
    if (ph_q == PH_DIV) begin
      // tempo event waits until the divider is through and the result register is free
      if (div_sts_i.done && !div_sts_i.busy && !(ov_q && out_stall_i)) begin
        emit = 1'b1; k_d = K_TEMPO; ts_d = tick_q; st_d = META_TEMPO; d1_d = bpm_i;
        ph_d = ret_q;
      end
    end else if (accept) begin
      if (restart_i) begin
        ph_d = PH_HDR; pos_d = 4'd0; tdec_d = 16'd0; tfin_d = 16'd0; left_d = 32'd0;
        tick_d = 32'd0; vl_d = 32'd0; rs_d = 8'd0; held_d = 8'd0; skip_d = 32'd0;
        tempo_d = 24'd0; dh_d = 8'd0; end_d = 1'b0; halt_d = 1'b0;
      end
      if (restart_i || (!halt_q && ph_q != PH_DONE)) begin
        if (restart_i || ph_q == PH_HDR) begin
          pos_d = (restart_i ? 4'd0 : pos_q) + 4'd1;
          if ((restart_i ? 4'd0 : pos_q) < 4'd4) begin
            if (b != TAG_HEADER[5'd24 - {(restart_i ? 2'd0 : pos_q[1:0]), 3'd0} +: 8])
            begin
              halt_d = 1'b1; emit = 1'b1; k_d = K_BAD_HDR;
            end
          end else if (pos_q == 4'd10 || pos_q == 4'd11) begin
            tdec_d = {tdec_q[7:0], b};
          end else if (pos_q == 4'd12) begin
            dh_d = b;
          end else if (pos_q >= 4'd13) begin
            emit = 1'b1; k_d = K_DIV;
            val_d = dh_q[7] ? prod[15:0] : {dh_q, b};
            pos_d = 4'd0;
            ph_d = (tdec_q != 16'd0) ? PH_TRK : PH_DONE;
          end
        end else if (ph_q == PH_TRK) begin
          pos_d = pos_q + 4'd1;
          if (pos_q < 4'd4) begin
            if (b != TAG_TRACK[5'd24 - {pos_q[1:0], 3'd0} +: 8]) begin
              halt_d = 1'b1; emit = 1'b1; k_d = K_BAD_TRK;
            end
          end else begin
            left_d = {left_q[23:0], b};
            left_n = left_d;
            if (pos_q >= 4'd7) begin
              tick_d = 32'd0; end_d = 1'b0; rs_d = 8'd0; pos_d = 4'd0; finish = 1'b1;
            end
          end
        end else begin
          if (left_q != 32'd0) left_d = left_q - 32'd1;
          left_n = left_d;
          unique case (ph_q)
            PH_DELTA: begin
              vl_d = vl_n;
              if (!b[7]) begin
                tick_d = tick_q + vl_n; ph_d = PH_STATUS;
              end
            end
            PH_STATUS, PH_DATA1: begin
              if (ph_q == PH_STATUS && b[7]) begin
                if (b >= 8'hF0) begin
                  rs_d = 8'd0; vl_d = 32'd0;
                  ph_d = (b == 8'hFF) ? PH_META_TYPE : PH_SYSEX_LEN;
                end else begin
                  rs_d = b; ph_d = PH_DATA1;
                end
              end else if (ph_q == PH_STATUS && rs_q == 8'd0) begin
                halt_d = 1'b1; emit = 1'b1; k_d = K_BAD_STAT; ts_d = tick_q; d1_d = b;
              end else begin
                held_d = b;
                if (hi == 8'hC0 || hi == 8'hD0) begin
                  emit = 1'b1; k_d = (hi == 8'hC0) ? K_PROG : K_CHAT;
                  ch_d = rs_q[3:0]; ts_d = tick_q; st_d = rs_q; d1_d = b;
                  finish = 1'b1;
                end else begin
                  ph_d = PH_DATA2;
                end
              end
            end
            PH_DATA2: begin
              ch_d = rs_q[3:0]; ts_d = tick_q; st_d = rs_q; d1_d = held_q; d2_d = b;
              emit = 1'b1;
              case (hi)
                8'h80: begin k_d = K_NOTE; st_d = rs_q + 8'h10; d2_d = 8'd0; end
                8'h90: k_d = K_NOTE;
                8'hA0: k_d = K_POLY;
                8'hB0: begin
                  k_d = K_CTRL;
                  emit = held_q == 8'd1 || held_q == 8'd7 || held_q == 8'd10;
                end
                default: k_d = K_PITCH;
              endcase
              finish = 1'b1;
            end
            PH_META_TYPE: begin
              held_d = b; vl_d = 32'd0; ph_d = PH_META_LEN;
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
              vl_d = vl_n;
              if (!b[7]) begin
                if (ph_q == PH_META_LEN && held_q == META_TEMPO) begin
                  skip_d = (vl_n > 32'd3) ? vl_n - 32'd3 : 32'd0;
                  tempo_d = 24'd0; pos_d = 4'd0; ph_d = PH_TEMPO;
                end else begin
                  if (ph_q == PH_META_LEN && held_q == META_END) end_d = 1'b1;
                  skip_d = vl_n;
                  if (vl_n == 32'd0) finish = 1'b1; else ph_d = PH_SKIP;
                end
              end
            end
            PH_TEMPO: begin
              tempo_d = {tempo_q[15:0], b};
              pos_d = pos_q + 4'd1;
              if (pos_q >= 4'd2) begin
                if (tempo_d == 24'd0) begin
                  emit = 1'b1; k_d = K_TEMPO; ts_d = tick_q; st_d = META_TEMPO;
                  d1_d = 8'hFF;
                end else begin
                  startdiv = 1'b1;
                end
                if (skip_q == 32'd0) finish = 1'b1; else ph_d = PH_SKIP;
              end
            end
            default: begin
              if (skip_q > 32'd1) skip_d = skip_q - 32'd1;
              else begin
                skip_d = 32'd0; finish = 1'b1;
              end
            end
          endcase
        end
      end
    end
    // end of event bookkeeping
    fin_tfin = tfin_q + {15'd0, end_d};
    fin_ph = PH_DELTA; fin_pos = pos_d;
    if (left_n == 32'd0) begin
      if (fin_tfin == tdec_d) fin_ph = PH_DONE;
      else begin
        fin_ph = PH_TRK; fin_pos = 4'd0;
      end
    end
    if (finish) begin
      if (ph_q != PH_TRK && left_n == 32'd0) tfin_d = fin_tfin;
      ph_d = fin_ph; pos_d = fin_pos; if (fin_ph == PH_DELTA) vl_d = 32'd0;
    end
    if (startdiv) begin
      ret_d = ph_d; ph_d = PH_DIV;
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (emit) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_HDR; ret_q <= PH_HDR; pos_q <= 4'd0; tdec_q <= 16'd0; tfin_q <= 16'd0;
      left_q <= 32'd0; tick_q <= 32'd0; vl_q <= 32'd0; skip_q <= 32'd0; rs_q <= 8'd0;
      held_q <= 8'd0; dh_q <= 8'd0; tempo_q <= 24'd0; end_q <= 1'b0; halt_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      ph_q <= ph_d; ret_q <= ret_d; pos_q <= pos_d; tdec_q <= tdec_d; tfin_q <= tfin_d;
      left_q <= left_d; tick_q <= tick_d; vl_q <= vl_d; skip_q <= skip_d; rs_q <= rs_d;
      held_q <= held_d; dh_q <= dh_d; tempo_q <= tempo_d; end_q <= end_d;
      halt_q <= halt_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      k_q <= k_d; ch_q <= ch_d; ts_q <= ts_d; st_q <= st_d; d1_q <= d1_d; d2_q <= d2_d;
      val_q <= val_d;
    end
  end

  assign div_cmd_o.start = startdiv;
  assign divisor_o = tempo_d;
  assign out_valid_o = ov_q;
  assign kind_o = k_q;
  assign channel_o = ch_q;
  assign timestamp_o = ts_q;
  assign status_o = st_q;
  assign data_first_o = d1_q;
  assign data_second_o = d2_q;
  assign value_o = val_q;
endmodule

[rtl/midi_file_event_parser_unit.sv]
// midi file event parser: byte stream in, decoded events out
// input channel: one file byte per request with restart flag, in_valid_i / in_stall_o
// output channel: one event per request, out_valid_o / out_stall_i, registered
// an event appears in the cycle after the byte that completes it, but for a divided tempo event
// throughput is one byte per cycle when not stalled; a tempo event with a nonzero
// period runs the bit-serial divider, which holds the input until the tempo event is emitted
// a waiting event stalls input only when the receiver stalls it
// reset clears the parser to expect a file header; restart on a byte does
// the same with that byte taken as header byte 0
// errors halt the parser until restart; bytes past the last track are dropped
`timescale 1ns / 1ps
module midi_file_event_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [3:0]  channel_o,
  output logic [31:0] timestamp_o,
  output logic [7:0]  status_o,
  output logic [7:0]  data_first_o,
  output logic [7:0]  data_second_o,
  output logic [15:0] value_o
);
  import mfep_pkg::*;

  div_cmd_t    cmd;
  div_sts_t    sts;
  logic [23:0] divisor;
  logic [7:0]  bpm;

  mfep_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .file_byte_i, .restart_i,
    .div_cmd_o(cmd), .divisor_o(divisor), .div_sts_i(sts), .bpm_i(bpm),
    .out_valid_o, .out_stall_i, .kind_o, .channel_o, .timestamp_o, .status_o,
    .data_first_o, .data_second_o, .value_o
  );

  mfep_div u_div (
    .clk_i, .rst_ni, .cmd_i(cmd), .divisor_i(divisor), .sts_o(sts), .bpm_o(bpm)
  );
endmodule
